// ===== src/lgs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared constants, types and the B3/S23 rule for the Life stencil.
// ----------------------------------------------------------------------------
package lgs_pkg;

  localparam int CFG_W           = 11;
  localparam int DEF_MAX_SIDE    = 1024;
  localparam int GRID_SIDE_RESET = 1024;
  localparam int MIN_SIDE        = 3;

  localparam int CELLS      = 3;
  localparam int COL_H      = 3;
  localparam int WIN_W      = CELLS * COL_H;
  localparam int CENTRE_BIT = 4;
  localparam int COUNT_W    = 4;

  localparam logic [COUNT_W-1:0] BIRTH_COUNT = COUNT_W'(3);
  localparam logic [COUNT_W-1:0] KEEP_COUNT  = COUNT_W'(2);

  localparam int Q_DEPTH = 4;
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  localparam int LINE_W = 2;

  typedef struct packed {
    logic first;
    logic prod;
    logic last;
  } tag_t;

  typedef struct packed {
    logic next_alive;
    logic cell_changed;
    logic any_changed;
    logic last;
  } result_t;

  function automatic logic next_of(input logic [WIN_W-1:0] win);
    logic [COUNT_W-1:0] n;
    logic               nxt;
    n = '0;
    for (int i = 0; i < WIN_W; i++) begin
      if (i != CENTRE_BIT) n = n + COUNT_W'(win[i]);
    end
    if (n == BIRTH_COUNT) nxt = 1'b1;
    else if (n == KEEP_COUNT) nxt = win[CENTRE_BIT];
    else nxt = 1'b0;
    return nxt;
  endfunction

endpackage

// ===== src/lgs_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgs_in_if / lgs_out_if
// Valid/ready channels for incoming cells and outgoing results.
// ----------------------------------------------------------------------------
interface lgs_in_if;
  logic valid;
  logic ready;
  logic cell_alive;

  modport source (output valid, output cell_alive, input ready);
  modport sink   (input valid, input cell_alive, output ready);
endinterface

interface lgs_out_if;
  logic valid;
  logic ready;
  logic next_alive;
  logic cell_changed;
  logic any_changed;
  logic last;

  modport source (output valid, output next_alive, output cell_changed,
                  output any_changed, output last, input ready);
  modport sink   (input valid, input next_alive, input cell_changed,
                  input any_changed, input last, output ready);
endinterface

// ===== src/lgs_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgs_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lgs_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/lgs_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgs_cell
// One column of the 3x3 window; shifts its column on to the next cell.
// ----------------------------------------------------------------------------
module lgs_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     clear_i,
  input  logic                     shift_i,
  input  logic [lgs_pkg::COL_H-1:0] col_i,
  output logic [lgs_pkg::COL_H-1:0] col_o
);
  import lgs_pkg::*;

  logic [COL_H-1:0] col_q, col_d;

  always_comb begin
    col_d = col_q;
    if (clear_i) col_d = '0;
    else if (shift_i) col_d = col_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else begin
      col_q <= col_d;
    end
  end

  assign col_o = col_q;

endmodule

// ===== src/lgs_out_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgs_out_queue
// Small result queue decoupling the stencil pipeline from the receiver.
// ----------------------------------------------------------------------------
module lgs_out_queue (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  lgs_pkg::result_t          push_data_i,
  input  logic                      pop_i,
  output logic                      valid_o,
  output lgs_pkg::result_t          data_o,
  output logic [lgs_pkg::QCNT_W-1:0] count_o
);
  import lgs_pkg::*;

  result_t             entry_q [Q_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]   count_q, count_d;
  logic                pop;

  assign valid_o = (count_q != '0);
  assign pop     = pop_i && valid_o;
  assign data_o  = entry_q[rd_ptr_q];
  assign count_o = count_q;

  always_comb begin
    wr_ptr_d = push_i ? QPTR_W'((32'(wr_ptr_q) + 1) % Q_DEPTH) : wr_ptr_q;
    rd_ptr_d = pop    ? QPTR_W'((32'(rd_ptr_q) + 1) % Q_DEPTH) : rd_ptr_q;
    count_d  = count_q + QCNT_W'(push_i) - QCNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== src/life_generation_stencil.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_generation_stencil
// One B3/S23 Life generation over a bordered square grid, streamed in
// raster order, border cells included.
//
// Channels: in_i takes one cell per request; out_o gives one result per
// interior cell. cfg_we_i/cfg_wdata_i set the side of the bordered grid
// (clamped to 3..MAX_SIDE) and restart the generation.
// Throughput: one cell per cycle while in_i.ready is high.
// Path: the request that completes a 3x3 neighbourhood passes stage 1,
// the window and stage 2, and the result queue before its result is on out_o.
// Line stores: one MAX_SIDE x 2 RAM, read and rewritten once per cell.
// The window is a chain of three column cells.
// Stall: a four-entry result queue absorbs the pipeline; in_i.ready
// falls only when the queue and the two stages in flight would overflow.
// Reset: side returns to 1024 (or MAX_SIDE if smaller), positions,
// window and the changed flag clear. No clearing pass is needed.
// ----------------------------------------------------------------------------
module life_generation_stencil #(
  parameter int MAX_SIDE = lgs_pkg::DEF_MAX_SIDE
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [lgs_pkg::CFG_W-1:0] cfg_wdata_i,
  lgs_in_if.sink                    in_i,
  lgs_out_if.source                 out_o
);
  import lgs_pkg::*;

  localparam int IDX_W      = $clog2(MAX_SIDE);
  localparam int RESET_SIDE = (GRID_SIDE_RESET > MAX_SIDE) ? MAX_SIDE : GRID_SIDE_RESET;
  localparam logic [IDX_W-1:0] LAST_RESET = IDX_W'(RESET_SIDE - 1);

  logic [IDX_W-1:0] last_q, last_d;
  logic [IDX_W-1:0] col_q, col_d;
  logic [IDX_W-1:0] row_q, row_d;
  logic             accept;
  int unsigned      side_req;

  logic             s1_valid_q;
  tag_t             s1_tag_q, s1_tag_d;
  logic [IDX_W-1:0] s1_addr_q;
  logic             s1_bot_q;
  logic [LINE_W-1:0] line_rd;
  logic [LINE_W-1:0] line_wr;

  logic [COL_H-1:0] chain [CELLS+1];
  logic [WIN_W-1:0] window;

  logic             s2_valid_q;
  tag_t             s2_tag_q;
  logic             any_q, any_d;
  result_t          res;
  logic             push;

  logic              q_valid;
  result_t           q_data;
  logic [QCNT_W-1:0] q_count;
  logic [QCNT_W:0]   pending;

  // Side register and raster position
  always_comb begin
    side_req = 32'(cfg_wdata_i);
    if (side_req < 32'(MIN_SIDE)) side_req = 32'(MIN_SIDE);
    if (side_req > 32'(MAX_SIDE)) side_req = 32'(MAX_SIDE);
    last_d = cfg_we_i ? IDX_W'(side_req - 1) : last_q;
  end

  assign accept = in_i.valid && in_i.ready;

  always_comb begin
    s1_tag_d.first = (row_q == '0) && (col_q == '0);
    s1_tag_d.prod  = (row_q >= IDX_W'(2)) && (col_q >= IDX_W'(2));
    s1_tag_d.last  = (row_q == last_q) && (col_q == last_q);
    col_d = col_q;
    row_d = row_q;
    if (cfg_we_i) begin
      col_d = '0;
      row_d = '0;
    end else if (accept) begin
      if (col_q == last_q) begin
        col_d = '0;
        row_d = (row_q == last_q) ? '0 : row_q + IDX_W'(1);
      end else begin
        col_d = col_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= LAST_RESET;
      col_q  <= '0;
      row_q  <= '0;
    end else begin
      last_q <= last_d;
      col_q  <= col_d;
      row_q  <= row_d;
    end
  end

  // Stage 1: line store read, rewritten in the following cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_tag_q  <= s1_tag_d;
      s1_addr_q <= col_q;
      s1_bot_q  <= in_i.cell_alive;
    end
  end

  // bit 0 upper row, bit 1 middle row
  assign line_wr = {s1_bot_q, line_rd[1]};

  lgs_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_SIDE)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_addr_q),
    .wdata_i (line_wr),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (line_rd)
  );

  // Window: chain of column cells, newest first
  assign chain[0] = {s1_bot_q, line_rd[1], line_rd[0]};

  for (genvar g = 0; g < CELLS; g++) begin : g_cell
    lgs_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .clear_i (cfg_we_i),
      .shift_i (s1_valid_q),
      .col_i   (chain[g]),
      .col_o   (chain[g+1])
    );
    assign window[WIN_W-1-g*COL_H -: COL_H] = chain[g+1];
  end

  // Stage 2: rule evaluation
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      any_q      <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
      any_q      <= any_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      s2_tag_q <= s1_tag_q;
    end
  end

  always_comb begin
    res.next_alive   = next_of(window);
    res.cell_changed = res.next_alive ^ window[CENTRE_BIT];
    res.last         = s2_tag_q.last;
    res.any_changed  = (s2_tag_q.first ? 1'b0 : any_q)
                       | (s2_tag_q.prod & res.cell_changed);
    push             = s2_valid_q && s2_tag_q.prod;
    any_d            = any_q;
    if (cfg_we_i) any_d = 1'b0;
    else if (s2_valid_q) any_d = res.any_changed;
  end

  lgs_out_queue u_out_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (res),
    .pop_i       (out_o.ready),
    .valid_o     (q_valid),
    .data_o      (q_data),
    .count_o     (q_count)
  );

  // Room for everything already in flight plus the next request
  assign pending = {1'b0, q_count}
                   + (QCNT_W+1)'(s1_valid_q && s1_tag_q.prod)
                   + (QCNT_W+1)'(push);
  assign in_i.ready = (pending < (QCNT_W+1)'(Q_DEPTH));

  assign out_o.valid        = q_valid;
  assign out_o.next_alive   = q_data.next_alive;
  assign out_o.cell_changed = q_data.cell_changed;
  assign out_o.any_changed  = q_data.any_changed;
  assign out_o.last         = q_data.last;

endmodule

// ===== src/lgs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgs_checker
// Port-level checks for the Life stencil, bound to the top level.
// ----------------------------------------------------------------------------
module lgs_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic next_alive_i,
  input logic cell_changed_i,
  input logic any_changed_i,
  input logic last_i
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(next_alive_i)
      && $stable(cell_changed_i) && $stable(any_changed_i) && $stable(last_i))
    else $error("stalled result changed");

  // a changed cell must show in the running flag
  a_changed_any: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && cell_changed_i |-> any_changed_i)
    else $error("cell_changed without any_changed");

  // input back-pressure only while results are pending
  a_ready_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled with no result pending");

endmodule

bind life_generation_stencil lgs_checker u_lgs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .next_alive_i   (out_o.next_alive),
  .cell_changed_i (out_o.cell_changed),
  .any_changed_i  (out_o.any_changed),
  .last_i         (out_o.last)
);

// ===== verif/life_generation_stencil_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_generation_stencil_test
// Self-checking bench for the B3/S23 Life stencil. Bordered grids are
// streamed cell by cell in raster order. A local line-store predictor
// works out each interior result, and the checker compares it field by
// field. Covers the rule cases on 3x3 grids, side clamping at both ends,
// a restart in mid-generation, a long output hold-off and random grids
// with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module life_generation_stencil_test;
  import lgs_pkg::*;

  localparam int SIDE_LIMIT   = DEF_MAX_SIDE;
  localparam int IDLE_LIMIT   = 5000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int WIDE_CELLS   = 64;
  localparam int RANDOM_CELLS = 400;

  typedef enum int unsigned {RX_FREE, RX_HALF, RX_MOSTLY, RX_PERIODIC} rx_mode_e;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             cfg_we_i    = 1'b0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;

  lgs_in_if  in_ch ();
  lgs_out_if out_ch ();

  life_generation_stencil i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predictor state
  int unsigned      side_now;
  int unsigned      col_pos;
  int unsigned      row_pos;
  logic             upper_row [SIDE_LIMIT];
  logic             middle_row [SIDE_LIMIT];
  logic [WIN_W-1:0] window;
  logic             changed_acc;
  result_t          next_gen_q [$];

  int unsigned cells_sent      = 0;
  int unsigned results_checked = 0;
  int unsigned generations     = 0;
  int unsigned cfg_writes      = 0;
  int unsigned input_stalls    = 0;
  int unsigned mismatches      = 0;
  int unsigned quiet_cycles    = 0;
  int unsigned holds_requested = 0;
  int unsigned holds_done      = 0;
  int unsigned burst_left      = 0;
  bit          gapless         = 1'b0;

  function automatic void restart_generation();
    col_pos     = 0;
    row_pos     = 0;
    window      = '0;
    changed_acc = 1'b0;
  endfunction

  function automatic void load_grid_side(input logic [CFG_W-1:0] value);
    if (value < MIN_SIDE) side_now = MIN_SIDE;
    else if (value > SIDE_LIMIT) side_now = SIDE_LIMIT;
    else side_now = value;
    restart_generation();
  endfunction

  function automatic void advance_generation(input logic alive);
    logic        top;
    logic        mid;
    logic        centre;
    logic        nxt;
    int unsigned count;
    result_t     res;
    if (row_pos == 0 && col_pos == 0) changed_acc = 1'b0;
    top = upper_row[col_pos];
    mid = middle_row[col_pos];
    upper_row[col_pos]  = mid;
    middle_row[col_pos] = alive;
    // newest column enters at the top bits: bottom, middle, top
    window = {alive, mid, top, window[WIN_W-1:COL_H]};
    if (row_pos >= 2 && col_pos >= 2) begin
      centre = window[CENTRE_BIT];
      count  = $countones(window) - centre;
      if (count == BIRTH_COUNT) nxt = 1'b1;
      else if (count == KEEP_COUNT) nxt = centre;
      else nxt = 1'b0;
      res.next_alive   = nxt;
      res.cell_changed = nxt ^ centre;
      changed_acc      = changed_acc | res.cell_changed;
      res.any_changed  = changed_acc;
      res.last         = (row_pos == side_now - 1) && (col_pos == side_now - 1);
      next_gen_q.push_back(res);
    end
    col_pos++;
    if (col_pos >= side_now) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= side_now) row_pos = 0;
    end
  endfunction

  task automatic pace_sender();
    int unsigned gap;
    if (gapless) return;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 30);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
  endtask

  task automatic send_cell(input logic alive);
    in_ch.valid      <= 1'b1;
    in_ch.cell_alive <= alive;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    advance_generation(alive);
    cells_sent++;
  endtask

  task automatic send_cells(input int unsigned n, input int unsigned density_pct);
    for (int unsigned i = 0; i < n; i++) begin
      pace_sender();
      send_cell($urandom_range(0, 99) < density_pct);
    end
  endtask

  task automatic send_pattern(input logic [WIN_W-1:0] cells);
    for (int i = 0; i < WIN_W; i++) begin
      pace_sender();
      send_cell(cells[i]);
    end
  endtask

  // only while idle: results drained and the pipeline given time to empty
  task automatic write_grid_side(input logic [CFG_W-1:0] value);
    in_ch.valid <= 1'b0;
    while (next_gen_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    load_grid_side(value);
    cfg_writes++;
  endtask

  // full-size side: the first row only, nothing is due yet
  task automatic test_reset_side();
    send_cells(WIDE_CELLS, 50);
  endtask

  // 3x3 grids, one interior cell each; sides below 3 clamp up
  task automatic test_rule_cases();
    write_grid_side(CFG_W'(0));
    send_pattern(9'h1FF);  // overcrowded, dies
    send_pattern(9'h000);  // stays empty
    send_pattern(9'h007);  // birth on three
    write_grid_side(CFG_W'(2));
    send_pattern(9'h005);  // two neighbours, stays dead
    send_pattern(9'h013);  // survives on two
    send_pattern(9'h017);  // survives on three
    write_grid_side(CFG_W'(MIN_SIDE));
    send_pattern(9'h011);  // lonely, dies
    send_pattern(9'h01F);  // four neighbours, dies
  endtask

  task automatic test_restart();
    write_grid_side(CFG_W'(5));
    send_cells(14, 50);
    write_grid_side(CFG_W'(5));
    send_cells(2 * 25, 40);
  endtask

  task automatic test_side_above_max();
    write_grid_side({CFG_W{1'b1}});
    send_cells(WIDE_CELLS, 50);
  endtask

  task automatic test_backpressure();
    write_grid_side(CFG_W'(8));
    holds_requested++;
    gapless = 1'b1;
    send_cells(3 * 64, 40);
    gapless = 1'b0;
  endtask

  task automatic test_random_grids();
    int unsigned done_cells;
    int unsigned side;
    int unsigned gens;
    int unsigned density;
    int unsigned pick;
    done_cells = 0;
    while (done_cells < RANDOM_CELLS) begin
      pick = $urandom_range(0, 19);
      if (pick < 14) side = $urandom_range(MIN_SIDE, 8);
      else if (pick < 19) side = $urandom_range(9, 20);
      else side = $urandom_range(21, 32);
      write_grid_side(CFG_W'(side));
      gens = $urandom_range(1, 3);
      for (int unsigned g = 0; g < gens; g++) begin
        if (done_cells >= RANDOM_CELLS) break;
        case ($urandom_range(0, 5))
          0:       density = 0;
          1:       density = 15;
          2:       density = 35;
          3:       density = 50;
          4:       density = 75;
          default: density = 100;
        endcase
        if ($urandom_range(0, 9) == 0) begin
          // broken generation, cut short by the next side write
          pick = $urandom_range(1, side * side - 1);
          send_cells(pick, density);
          done_cells += pick;
          break;
        end
        send_cells(side * side, density);
        done_cells += side * side;
      end
    end
  endtask

  // receiver: stall pattern changes per stretch; hold-off on request
  initial begin
    rx_mode_e    mode;
    int unsigned stretch;
    int unsigned hold_left;
    int unsigned phase;
    out_ch.ready = 1'b0;
    mode      = RX_FREE;
    stretch   = 0;
    hold_left = 0;
    phase     = 0;
    forever begin
      @(posedge clk_i);
      if (holds_done != holds_requested) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        if (stretch == 0) begin
          mode    = rx_mode_e'($urandom_range(0, 3));
          stretch = $urandom_range(20, 200);
        end
        stretch--;
        phase++;
        case (mode)
          RX_FREE:   out_ch.ready <= 1'b1;
          RX_HALF:   out_ch.ready <= $urandom_range(0, 1);
          RX_MOSTLY: out_ch.ready <= ($urandom_range(0, 3) != 0);
          default:   out_ch.ready <= (phase % 5 != 0) && (phase % 7 != 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (next_gen_q.size() == 0) begin
        $error("result with no expectation waiting");
        mismatches++;
      end else begin
        want = next_gen_q.pop_front();
        results_checked++;
        if (want.last) generations++;
        if (out_ch.next_alive !== want.next_alive) begin
          $error("next_alive: expected %0b, got %0b", want.next_alive, out_ch.next_alive);
          mismatches++;
        end
        if (out_ch.cell_changed !== want.cell_changed) begin
          $error("cell_changed: expected %0b, got %0b", want.cell_changed,
                 out_ch.cell_changed);
          mismatches++;
        end
        if (out_ch.any_changed !== want.any_changed) begin
          $error("any_changed: expected %0b, got %0b", want.any_changed, out_ch.any_changed);
          mismatches++;
        end
        if (out_ch.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_ch.last);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni && in_ch.valid && !in_ch.ready) input_stalls <= input_stalls + 1;
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.cell_alive = 1'b0;
    foreach (upper_row[i]) begin
      upper_row[i]  = 1'b0;
      middle_row[i] = 1'b0;
    end
    load_grid_side(CFG_W'(GRID_SIDE_RESET));
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_side();
    test_rule_cases();
    test_restart();
    test_side_above_max();
    test_backpressure();
    test_random_grids();
    in_ch.valid <= 1'b0;
    while (next_gen_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Run covered %0d cells, %0d results checked, %0d generations closed.",
             cells_sent, results_checked, generations);
    $display("%0d side writes incl. clamped extremes; input held off on %0d cycles.",
             cfg_writes, input_stalls);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/lgs_pkg.sv
src/lgs_stream_if.sv
src/lgs_ram.sv
src/lgs_cell.sv
src/lgs_out_queue.sv
src/life_generation_stencil.sv
src/lgs_checker.sv
verif/life_generation_stencil_test.sv
